/* design/rp2s_pkg.sv */
// Shared types and constants for the power-of-two radix string to double converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rp2s_pkg;

	localparam int CHAR_FIELD_W  = 16;
	localparam int COUNT_FIELD_W = 16;
	localparam int VALUE_W       = 64;
	localparam int FRAC_W        = 52;
	localparam int SIG_W         = 12;
	localparam int OUT_DATA_W    = VALUE_W + COUNT_FIELD_W;

	localparam int DEF_CHAR_WIDTH  = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [SIG_W-1:0]   SIG_MAX    = 12'd4095;
	localparam logic [SIG_W-1:0]   FRAC_LAST  = 12'd52;
	localparam logic [SIG_W-1:0]   ROUND_POS  = 12'd53;
	localparam logic [SIG_W:0]     EXP_BIAS   = 13'd1022;
	localparam logic [SIG_W:0]     EXP_LIMIT  = 13'd2046;
	localparam logic [VALUE_W-1:0] INF_BITS   = 64'h7FF0_0000_0000_0000;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	// One classified character: a terminator, or a digit with its bit count.
	typedef struct packed {
		logic       term;
		logic [3:0] digit;
		logic [2:0] nbits;
	} entry_t;

endpackage

/* design/rp2s_front.sv */
// Front end: holds the radix register and classifies each character request.
// Depends on rp2s_pkg.
module rp2s_front #(
	parameter int CHAR_WIDTH = rp2s_pkg::DEF_CHAR_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_data,
	input  logic [rp2s_pkg::CHAR_FIELD_W-1:0]     char_code,
	output rp2s_pkg::entry_t                      entry
);
	import rp2s_pkg::*;

	logic [1:0]              radix_q;
	logic [CHAR_FIELD_W-1:0] ch;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_HEX;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	// Bits above the configured character width are ignored.
	always_comb begin
		for (int k = 0; k < CHAR_FIELD_W; k++) begin
			ch[k] = char_code[k] & (k < CHAR_WIDTH);
		end
	end

	always_comb begin
		entry.term  = 1'b0;
		entry.digit = ch[3:0];
		entry.nbits = 3'd4;
		case (radix_q)
			RADIX_BIN: begin
				entry.nbits = 3'd1;
				entry.term  = !(ch inside {16'h30, 16'h31});
			end
			RADIX_OCT: begin
				entry.nbits = 3'd3;
				entry.term  = !(ch inside {[16'h30:16'h37]});
			end
			default: begin
				if (ch inside {[16'h30:16'h39]}) begin
					entry.digit = ch[3:0];
				end else if (ch inside {[16'h41:16'h46], [16'h61:16'h66]}) begin
					entry.digit = 4'(ch[2:0] + 3'd1) + 4'd8;
				end else begin
					entry.term = 1'b1;
				end
			end
		endcase
	end

endmodule

/* design/rp2s_queue.sv */
// Short queue between front and back so either side can stall on its own.
// Depends on rp2s_pkg.
module rp2s_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rp2s_pkg::entry_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output rp2s_pkg::entry_t  pop_data
);
	import rp2s_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* design/rp2s_back.sv */
// Back end: accumulates significant bits, rounds on the terminator and holds
// the result in an output register. Depends on rp2s_pkg.
module rp2s_back #(
	parameter int COUNT_WIDTH = rp2s_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 empty,
	input  rp2s_pkg::entry_t                     entry,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rp2s_pkg::VALUE_W-1:0]         value_bits,
	output logic [rp2s_pkg::COUNT_FIELD_W-1:0]   consumed_count
);
	import rp2s_pkg::*;

	logic                   phase_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [SIG_W-1:0]       sig_q;
	logic                   round_q;
	logic                   sticky_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic                   out_valid_q;
	logic [VALUE_W-1:0]     out_bits_q;
	logic [COUNT_FIELD_W-1:0] out_cnt_q;

	logic              ph_n;
	logic [FRAC_W-1:0] frac_n;
	logic [SIG_W-1:0]  sig_n;
	logic              round_n;
	logic              sticky_n;
	logic              bit_v;
	logic [5:0]        pos;

	logic [SIG_W:0]    expo;
	logic [VALUE_W-1:0] base_bits;
	logic [VALUE_W-1:0] result;
	logic              round_up;
	logic              out_free;

	assign out_free       = !out_valid_q || out_ready;
	assign pop            = !empty && (!entry.term || out_free);
	assign out_valid      = out_valid_q;
	assign value_bits     = out_bits_q;
	assign consumed_count = out_cnt_q;

	// Digit bits go in most significant first, up to four per request.
	always_comb begin
		ph_n     = phase_q;
		frac_n   = frac_q;
		sig_n    = sig_q;
		round_n  = round_q;
		sticky_n = sticky_q;
		bit_v    = 1'b0;
		pos      = '0;
		for (int i = 3; i >= 0; i--) begin
			if (i < int'(entry.nbits)) begin
				bit_v = entry.digit[i];
				pos   = 6'(FRAC_LAST - sig_n);
				if (!ph_n) begin
					if (bit_v) begin
						ph_n  = 1'b1;
						sig_n = 12'd1;
					end
				end else begin
					if (sig_n <= FRAC_LAST) begin
						frac_n[pos] = frac_n[pos] | bit_v;
					end else if (sig_n == ROUND_POS) begin
						round_n = round_n | bit_v;
					end else begin
						sticky_n = sticky_n | bit_v;
					end
					if (sig_n < SIG_MAX) begin
						sig_n = sig_n + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		expo      = {1'b0, sig_q} + EXP_BIAS;
		base_bits = {1'b0, expo[10:0], frac_q};
		round_up  = round_q && (sticky_q || frac_q[0]);
		if (!phase_q) begin
			result = '0;
		end else if (expo > EXP_LIMIT) begin
			result = INF_BITS;
		end else begin
			result = base_bits + VALUE_W'(round_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			frac_q      <= '0;
			sig_q       <= '0;
			round_q     <= 1'b0;
			sticky_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && entry.term) begin
				phase_q     <= 1'b0;
				frac_q      <= '0;
				sig_q       <= '0;
				round_q     <= 1'b0;
				sticky_q    <= 1'b0;
				cnt_q       <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					phase_q  <= ph_n;
					frac_q   <= frac_n;
					sig_q    <= sig_n;
					round_q  <= round_n;
					sticky_q <= sticky_n;
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && entry.term) begin
			out_bits_q <= result;
			out_cnt_q  <= COUNT_FIELD_W'(cnt_q);
		end
	end

endmodule

/* design/radix_pow2_string_to_double_unit.sv */
// A terminating character request passes through the queue and then the output register
// before its result appears on m_tvalid. Throughput: one character per cycle while s_tready
// is high; the four-entry queue and the output register let the stream continue
// while a result waits.
// Reset (arst_n low): queue and accumulator empty, no result pending, radix hex.
// Depends on rp2s_pkg, rp2s_front, rp2s_queue and rp2s_back.
module radix_pow2_string_to_double_unit #(
	parameter int CHAR_WIDTH  = rp2s_pkg::DEF_CHAR_WIDTH,
	parameter int COUNT_WIDTH = rp2s_pkg::DEF_COUNT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rp2s_pkg::CHAR_FIELD_W-1:0] s_tdata,   // [15:0] char_code
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rp2s_pkg::OUT_DATA_W-1:0]   m_tdata    // [63:0] value_bits, [79:64] consumed_count
);
	import rp2s_pkg::*;

	entry_t                   front_entry;
	entry_t                   back_entry;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic [VALUE_W-1:0]       value_bits;
	logic [COUNT_FIELD_W-1:0] consumed_count;

	assign s_tready = !q_full;
	assign m_tdata  = {consumed_count, value_bits};

	rp2s_front #(
		.CHAR_WIDTH(CHAR_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.char_code(s_tdata),
		.entry    (front_entry)
	);

	rp2s_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid && !q_full),
		.push_data(front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_data (back_entry)
	);

	rp2s_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.entry         (back_entry),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.value_bits    (value_bits),
		.consumed_count(consumed_count)
	);

endmodule

/* design/rp2s_checker.sv */
// Port-level checks for radix_pow2_string_to_double_unit, attached by bind.
// Depends on rp2s_pkg for the output width.
module rp2s_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rp2s_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rp2s_pkg::*;

	// A held result must not change while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Parsed strings are never negative.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[63])
		else $error("sign bit set");

	// Infinity is the only value with an all-ones exponent; no NaN appears.
	a_no_nan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[62:52] == 11'h7FF) |-> (m_tdata[51:0] == 52'd0))
		else $error("NaN produced");

	// A zero exponent only occurs for the value zero.
	a_no_subnormal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[62:52] == 11'd0) |-> (m_tdata[51:0] == 52'd0))
		else $error("subnormal produced");

endmodule

bind radix_pow2_string_to_double_unit rp2s_checker u_rp2s_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
